### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion shorthands; each expects clk and rst in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/wms_pkg.sv
// ---------------------------------------------------------------------------
// Weighted median select package
// Sizes, payload types and sequencer states shared across the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wms_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int VALUE_BITS  = 32;
  localparam int WEIGHT_BITS = 16;

  localparam int IDX_BITS     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int COUNT_BITS   = $clog2(MAX_ITEMS + 1);
  localparam int SUM_BITS     = WEIGHT_BITS + IDX_BITS;
  localparam int BAL_BITS     = SUM_BITS + 2;
  localparam int BAL_MAG_BITS = SUM_BITS + 1;
  localparam int PAIR_BITS    = VALUE_BITS + WEIGHT_BITS;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [WEIGHT_BITS-1:0]       weight_t;
  typedef logic [COUNT_BITS-1:0]        count_t;
  typedef logic [IDX_BITS-1:0]          idx_t;
  typedef logic [SUM_BITS-1:0]          sum_t;
  typedef logic signed [BAL_BITS-1:0]   bal_t;
  typedef logic [BAL_MAG_BITS-1:0]      bal_mag_t;
  typedef logic [PAIR_BITS-1:0]         pair_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_FETCH,
    S_LATCH,
    S_SCAN,
    S_DRAIN,
    S_EVAL,
    S_CMP,
    S_FINAL
  } state_t;

endpackage

### hdl/wms_ifs.sv
// ---------------------------------------------------------------------------
// Weighted median select channels
// Valid/ready channels for incoming pairs and outgoing results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wms_sample_if;
  import wms_pkg::*;

  logic    valid;
  logic    ready;
  value_t  sample_value;
  weight_t sample_weight;
  logic    last_of_set;

  modport source (output valid, sample_value, sample_weight, last_of_set, input ready);
  modport sink   (input valid, sample_value, sample_weight, last_of_set, output ready);
endinterface

interface wms_median_if;
  import wms_pkg::*;

  logic   valid;
  logic   ready;
  value_t median_value;
  count_t set_size;
  logic   zero_weight;
  logic   overflowed;

  modport source (output valid, median_value, set_size, zero_weight, overflowed, input ready);
  modport sink   (input valid, median_value, set_size, zero_weight, overflowed, output ready);
endinterface

### hdl/weighted_median_select_unit.sv
// ---------------------------------------------------------------------------
// Weighted median select unit
// Collects (value, weight) pairs and returns the weighted median of each set.
// ---------------------------------------------------------------------------
// Pairs arrive one per transfer on the sample channel and are written to a
// pair RAM at one per cycle; a pair with last_of_set closes the set and the
// unit stops taking pairs until the result is placed in the output register.
// Up to MAX_ITEMS pairs are kept; later ones are dropped and flagged. For a
// set of n kept pairs with nonzero total weight, selection sweeps the
// single RAM read port over all n pairs for each pair to find its rank and
// the weight ranked ahead of it (order by signed value, then weight, then
// arrival), followed by a balance and a compare step. An empty or
// zero-weight set skips the sweep and gives a result of 0. The result waits
// in the output register while the next set loads, so the output side may
// stall without blocking the sample side.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module weighted_median_select_unit (
  input  logic                clk,
  input  logic                rst,
  wms_sample_if.sink          sample,
  wms_median_if.source        median
);
  import wms_pkg::*;

  state_t   state;
  state_t   state_next;

  // Set accumulation
  count_t   count;
  sum_t     total;
  logic     ovf;
  logic     zero_flag;

  // Pivot pair under evaluation and its sweep results
  idx_t     outer_idx;
  idx_t     inner_idx;
  value_t   piv_value;
  weight_t  piv_weight;
  sum_t     below;
  idx_t     rank;
  bal_mag_t bal;

  // Read pipeline tag
  logic     scan_valid;
  idx_t     scan_idx;

  // Best pair so far
  value_t   best_value;
  bal_mag_t best_bal;
  idx_t     best_rank;

  // Output register
  logic     out_valid;
  value_t   out_value;
  count_t   out_size;
  logic     out_zero;
  logic     out_ovf;

  // RAM port
  logic     ram_we;
  idx_t     ram_raddr;
  pair_t    ram_wdata;
  pair_t    ram_rdata;
  value_t   rd_value;
  weight_t  rd_weight;

  logic     in_xfer;
  logic     out_xfer;
  logic     out_free;
  logic     out_load;
  logic     has_room;
  logic     set_empty;
  idx_t     last_idx;
  logic     precedes;
  bal_t     diff;
  bal_mag_t diff_mag;
  logic     better;

  assign in_xfer   = sample.valid && sample.ready;
  assign out_xfer  = median.valid && median.ready;
  assign out_free  = !out_valid || median.ready;
  assign out_load  = (state == S_FINAL) && out_free;
  assign has_room  = count < COUNT_BITS'(MAX_ITEMS);
  assign set_empty = (count == '0) || (total == '0);
  assign last_idx  = IDX_BITS'(count - COUNT_BITS'(1));

  assign sample.ready        = (state == S_LOAD);
  assign median.valid        = out_valid;
  assign median.median_value = out_value;
  assign median.set_size     = out_size;
  assign median.zero_weight  = out_zero;
  assign median.overflowed   = out_ovf;

  // Store each kept pair at the next free slot.
  assign ram_we    = in_xfer && has_room;
  assign ram_wdata = {sample.sample_value, sample.sample_weight};
  assign ram_raddr = (state == S_SCAN) ? inner_idx : outer_idx;

  wms_ram #(
    .WIDTH (PAIR_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_pair_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IDX_BITS-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_value  = value_t'(ram_rdata[PAIR_BITS-1:WEIGHT_BITS]);
  assign rd_weight = ram_rdata[WEIGHT_BITS-1:0];

  // The swept pair ranks ahead of the pivot: smaller value, then smaller
  // weight, and equal pairs keep arrival order.
  always_comb begin
    precedes = 1'b0;
    if (rd_value != piv_value) begin
      precedes = rd_value < piv_value;
    end else if (rd_weight != piv_weight) begin
      precedes = rd_weight < piv_weight;
    end else begin
      precedes = scan_idx < outer_idx;
    end
  end

  // Balance = |2*below + weight - total|.
  assign diff     = BAL_BITS'({below, 1'b0}) + BAL_BITS'(piv_weight) - BAL_BITS'(total);
  assign diff_mag = diff[BAL_BITS-1] ? BAL_MAG_BITS'(-diff) : BAL_MAG_BITS'(diff);

  // Ties go to the pair ranked earlier.
  assign better = (outer_idx == '0) || (bal < best_bal) ||
                  ((bal == best_bal) && (rank < best_rank));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (in_xfer && sample.last_of_set) begin
          state_next = S_START;
        end
      end
      S_START: begin
        state_next = set_empty ? S_FINAL : S_FETCH;
      end
      S_FETCH: begin
        state_next = S_LATCH;
      end
      S_LATCH: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (inner_idx == last_idx) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        state_next = (outer_idx == last_idx) ? S_FINAL : S_FETCH;
      end
      S_FINAL: begin
        if (out_free) begin
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      total      <= '0;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
      scan_valid <= 1'b0;
    end else begin
      // Raise valid when a result lands; drop it once the consumer takes it.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end

      // Tag each read issued in the sweep; its data lands in the next cycle.
      scan_valid <= (state == S_SCAN);
      scan_idx   <= inner_idx;

      // Accumulate the weight and rank ahead of the pivot.
      if (scan_valid && precedes) begin
        below <= below + SUM_BITS'(rd_weight);
        rank  <= rank + IDX_BITS'(1);
      end

      case (state)
        S_LOAD: begin
          outer_idx <= '0;
          if (in_xfer) begin
            if (has_room) begin
              count <= count + COUNT_BITS'(1);
              total <= total + SUM_BITS'(sample.sample_weight);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        S_START: begin
          zero_flag <= set_empty;
        end
        S_FETCH: begin
          inner_idx <= '0;
        end
        S_LATCH: begin
          piv_value  <= rd_value;
          piv_weight <= rd_weight;
          below      <= '0;
          rank       <= '0;
        end
        S_SCAN: begin
          inner_idx <= inner_idx + IDX_BITS'(1);
        end
        S_DRAIN: begin
        end
        S_EVAL: begin
          bal <= diff_mag;
        end
        S_CMP: begin
          if (better) begin
            best_value <= piv_value;
            best_bal   <= bal;
            best_rank  <= rank;
          end
          if (outer_idx != last_idx) begin
            outer_idx <= outer_idx + IDX_BITS'(1);
          end
        end
        S_FINAL: begin
          // Hold until the output register is free, then clear the set.
          if (out_free) begin
            out_value <= zero_flag ? value_t'(0) : best_value;
            out_size  <= count;
            out_zero  <= zero_flag;
            out_ovf   <= ovf;
            count     <= '0;
            total     <= '0;
            ovf       <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The kept-pair count never passes capacity.
  `ASSERT_ALWAYS(a_count_bound, count <= COUNT_BITS'(MAX_ITEMS))
  // A result transfer into the output register leaves an empty set behind.
  `ASSERT_NEXT(a_set_cleared, (state == S_FINAL) && out_free,
               (count == '0) && (total == '0) && !ovf && out_valid)
  // Read data is tagged only while a sweep is running.
  `ASSERT_IMPLIES(a_scan_window, scan_valid, (state == S_SCAN) || (state == S_DRAIN))
  // A selected pair always has a rank inside the set.
  `ASSERT_IMPLIES(a_rank_bound, (state == S_FINAL) && !zero_flag,
                  COUNT_BITS'(best_rank) < count)

endmodule

### hdl/wms_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
